@@ rtl/mtfc_pkg.sv @@
// Shared types and constants of the move-to-front codec.
package mtfc_pkg;

	// Width of one symbol and of one list position.
	localparam int SYM_W = 8;

	// Default alphabet size of the recency list.
	localparam int ALPHABET_SIZE_DEF = 256;

	// Number of cells folded together in the first stage of the search tree.
	localparam int RED_GROUP = 16;

	typedef logic [SYM_W-1:0] sym_t;

	// What one cell offers to the search: a hit and the value that goes with it.
	typedef struct packed {
		logic hit;
		sym_t data;
	} contrib_t;

	// Update broadcast to every cell of the list.
	typedef struct packed {
		logic apply;
		logic clear;
		logic move;
		sym_t pos;
		sym_t sym;
	} upd_t;

endpackage

@@ rtl/mtfc_if.sv @@
// Handshake interfaces for the input and result channels.
interface mtfc_in_if;
	logic              valid;
	logic              ready;
	mtfc_pkg::sym_t    value_in;
	logic              last_in;

	modport source (output valid, output value_in, output last_in, input ready);
	modport sink (input valid, input value_in, input last_in, output ready);
endinterface

interface mtfc_out_if;
	logic              valid;
	logic              ready;
	mtfc_pkg::sym_t    value_out;
	logic              last_out;

	modport source (output valid, output value_out, output last_out, input ready);
	modport sink (input valid, input value_out, input last_out, output ready);
endinterface

@@ rtl/mtfc_cell.sv @@
// One entry of the recency list with its match logic and shift move.
module mtfc_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                decode_mode,
	input  mtfc_pkg::sym_t      key,
	input  mtfc_pkg::sym_t      dec_pos,
	input  mtfc_pkg::upd_t      upd,
	input  mtfc_pkg::sym_t      left,
	output mtfc_pkg::sym_t      entry,
	output mtfc_pkg::contrib_t  contrib
);

	localparam mtfc_pkg::sym_t IDX_V = mtfc_pkg::sym_t'(IDX);

	mtfc_pkg::sym_t entry_q;
	logic           hit;

	assign entry = entry_q;

	// Encoding looks for the byte, decoding for the position.
	always_comb begin
		hit = decode_mode ? (dec_pos == IDX_V) : (entry_q == key);
		contrib.hit  = hit;
		contrib.data = hit ? (decode_mode ? entry_q : IDX_V) : '0;
	end

	// Cells at or below the moved position take their left neighbour's entry;
	// the front cell's neighbour is the moved symbol itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= IDX_V;
		end else if (upd.apply) begin
			if (upd.clear) begin
				entry_q <= IDX_V;
			end else if (upd.move && (IDX_V <= upd.pos)) begin
				entry_q <= left;
			end
		end
	end

endmodule

@@ rtl/mtfc_reduce.sv @@
// Two-stage registered OR tree that gathers the single hit of the cell row.
module mtfc_reduce #(
	parameter int N = mtfc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  mtfc_pkg::contrib_t  contrib [N],
	output mtfc_pkg::contrib_t  res
);

	localparam int GROUP = mtfc_pkg::RED_GROUP;
	localparam int NGRP  = (N + GROUP - 1) / GROUP;

	mtfc_pkg::contrib_t grp_s1 [NGRP];
	mtfc_pkg::contrib_t res_s2;

	assign res = res_s2;

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		mtfc_pkg::contrib_t member [GROUP];
		mtfc_pkg::contrib_t acc;

		for (genvar j = 0; j < GROUP; j++) begin : g_mem
			if (g * GROUP + j < N) begin : g_in
				assign member[j] = contrib[g*GROUP+j];
			end else begin : g_pad
				assign member[j] = '0;
			end
		end

		always_comb begin
			acc = '0;
			for (int j = 0; j < GROUP; j++) begin
				acc.hit  = acc.hit | member[j].hit;
				acc.data = acc.data | member[j].data;
			end
		end

		always_ff @(posedge clk) begin
			grp_s1[g] <= acc;
		end
	end

	mtfc_pkg::contrib_t total;

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total.hit  = total.hit | grp_s1[g].hit;
			total.data = total.data | grp_s1[g].data;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= total;
	end

endmodule

@@ rtl/move_to_front_codec_unit.sv @@
// Top level of the byte move-to-front codec: cell row, search tree and control.
//
//  Channel   Direction  Carries                       Handshake
//  in_ch     sink       value_in[7:0], last_in        valid/ready
//  out_ch    source     value_out[7:0], last_out      valid/ready
//  cfg       write      cfg_wdata = decode_mode       cfg_we, no wait
//
//  An item goes through capture, the first tree stage, the second tree stage,
//  then the list update together with loading the result register.
//  The two registered stages belong to the search over all cells;
//  the list itself shifts at once, in the same cycle as the result register loads.
//  A new word is accepted as soon as the previous update is done, even while
//  its result still waits in the output register.
//  A stalled output holds the update back until the result slot is free.
//  Reset puts the list in identity order at once; no clearing pass is needed.
module move_to_front_codec_unit #(
	parameter int ALPHABET_SIZE = mtfc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mtfc_in_if.sink      in_ch,
	mtfc_out_if.source   out_ch,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	// The control sequence walks through the search tree latency.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SUM,
		ST_APPLY
	} state_t;

	localparam logic [mtfc_pkg::SYM_W:0] LAST_POS_W = (mtfc_pkg::SYM_W+1)'(ALPHABET_SIZE - 1);
	localparam mtfc_pkg::sym_t LAST_POS = mtfc_pkg::sym_t'(ALPHABET_SIZE - 1);

	state_t             state_q;
	logic               decode_mode_q;
	mtfc_pkg::sym_t     val_q;
	logic               last_q;
	logic               out_valid_q;
	mtfc_pkg::sym_t     out_value_q;
	logic               out_last_q;

	mtfc_pkg::sym_t     dec_pos;
	mtfc_pkg::sym_t     entry [ALPHABET_SIZE];
	mtfc_pkg::contrib_t contrib [ALPHABET_SIZE];
	mtfc_pkg::contrib_t res;
	mtfc_pkg::upd_t     upd;
	logic               slot_free;
	logic               accept;

	// A decode position beyond the list saturates to its last entry.
	assign dec_pos = ({1'b0, val_q} > LAST_POS_W) ? LAST_POS : val_q;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign accept    = in_ch.valid && in_ch.ready;

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.value_out = out_value_q;
	assign out_ch.last_out  = out_last_q;

	// In encode mode the tree returns the position and the moved symbol is the
	// input; in decode mode it returns the symbol and the position is known.
	// A byte absent from the list leaves no hit, so nothing moves and the
	// result is zero. A last word resets the list after its result is formed.
	always_comb begin
		upd.apply = (state_q == ST_APPLY) && slot_free;
		upd.clear = last_q;
		upd.move  = res.hit;
		upd.pos   = decode_mode_q ? dec_pos : res.data;
		upd.sym   = decode_mode_q ? res.data : val_q;
	end

	// Each cell reads only its left neighbour; the front cell reads the symbol.
	for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
		mtfc_pkg::sym_t left;

		if (k == 0) begin : g_front
			assign left = upd.sym;
		end else begin : g_body
			assign left = entry[k-1];
		end

		mtfc_cell #(
			.IDX(k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.decode_mode (decode_mode_q),
			.key         (val_q),
			.dec_pos     (dec_pos),
			.upd         (upd),
			.left        (left),
			.entry       (entry[k]),
			.contrib     (contrib[k])
		);
	end

	mtfc_reduce #(
		.N(ALPHABET_SIZE)
	) u_reduce (
		.clk     (clk),
		.contrib (contrib),
		.res     (res)
	);

	// The user must write the mode register only while no word is in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (cfg_we) begin
			decode_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= in_ch.value_in;
			last_q <= in_ch.last_in;
		end
	end

	// Control sequence and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= res.data;
						out_last_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Decoding always finds its entry, since the position is saturated.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && decode_mode_q) |-> res.hit)
		else $error("decode search found no entry");

	// Encoding a byte inside the alphabet must find it in the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && !decode_mode_q && ({1'b0, val_q} <= LAST_POS_W)) |-> res.hit)
		else $error("encode search lost a byte of the alphabet");

	// After a move that is not a buffer end, the moved symbol sits in front.
	assert property (@(posedge clk) disable iff (!arst_n)
		(upd.apply && !upd.clear && upd.move) |=> (entry[0] == $past(upd.sym)))
		else $error("moved symbol did not reach the front");

	// A buffer end restores identity order at both ends of the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		(upd.apply && upd.clear) |=> (entry[0] == '0 && entry[ALPHABET_SIZE-1] == LAST_POS))
		else $error("list not back in identity order after last word");

	// A result is only loaded when the slot is empty or being emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(out_value_q)) || !arst_n)
		else $error("pending result overwritten");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the byte move-to-front codec unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The list size of the instance; the shadow model follows it.
	localparam int ALPHA = mtfc_pkg::ALPHABET_SIZE_DEF;

	// Allowance for the path from capture to the result register, used in the waits.
	localparam int LAT = 4;

	// Number of random words after the directed part.
	localparam int N_RANDOM = 700;

	// Words near the end of the run during which neither side stalls at random.
	localparam int N_QUIET = 120;

	// Length of the one long hold-off on the result side, in cycles.
	localparam int LONG_HOLD = 80;

	// Values of the decode_mode register.
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One result word as the block should produce it.
	typedef struct {
		mtfc_pkg::sym_t value;
		logic           last;
	} mtf_word_t;

	// Shadow of the recency list. Each accepted input word is pushed through the
	// same move-to-front step as the block performs, and the result it should
	// give is queued until the block hands the matching word back.
	class recency_shadow;
		mtfc_pkg::sym_t order [ALPHA];
		logic           decoding;
		mtf_word_t      expected_words [$];
		int             errors;

		function new();
			decoding = MODE_ENCODE;
			errors = 0;
			to_identity();
		endfunction

		function void to_identity();
			for (int k = 0; k < ALPHA; k++)
				order[k] = mtfc_pkg::sym_t'(k);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void predict_word(mtfc_pkg::sym_t v, logic l);
			int             pos;
			mtfc_pkg::sym_t moved;
			mtf_word_t      w;
			pos = -1;
			w.value = '0;
			w.last = l;
			if (decoding == MODE_DECODE) begin
				// A position past the end of the list saturates to the last entry.
				pos = (int'(v) > ALPHA - 1) ? ALPHA - 1 : int'(v);
				w.value = order[pos];
			end else begin
				for (int k = 0; k < ALPHA; k++) begin
					if (order[k] == v) begin
						pos = k;
						break;
					end
				end
				// A byte missing from the list gives position zero and no move.
				if (pos >= 0)
					w.value = mtfc_pkg::sym_t'(pos);
			end
			if (pos >= 0) begin
				moved = order[pos];
				for (int j = pos; j > 0; j--)
					order[j] = order[j - 1];
				order[0] = moved;
			end
			expected_words.push_back(w);
			// The end of a buffer puts the list back in identity order, after the
			// result of the closing word has been formed.
			if (l)
				to_identity();
		endfunction

		function void compare_word(mtfc_pkg::sym_t v, logic l);
			mtf_word_t w;
			if (expected_words.size() == 0) begin
				$error("result word with none expected: value_out %0d last_out %0d", v, l);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (v !== w.value) begin
				$error("value_out: expected %0d, actual %0d", w.value, v);
				errors++;
			end
			if (l !== w.last) begin
				$error("last_out: expected %0d, actual %0d", w.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	mtfc_in_if  in_ch ();
	mtfc_out_if out_ch ();

	recency_shadow shadow = new();

	// Set by the stimulus to ask the result side for one long hold-off.
	int hold_request = 0;

	// Once set, neither side stalls at random any more, so the tail of the run goes without random gaps.
	bit quiet = 1'b0;

	move_to_front_codec_unit #(
		.ALPHABET_SIZE(ALPHA)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offers one word and returns at the edge that accepts it. The valid stays high
	// on return, so a following call keeps the channel busy without a gap.
	task automatic send_word(input mtfc_pkg::sym_t v, input logic l);
		in_ch.valid    <= 1'b1;
		in_ch.value_in <= v;
		in_ch.last_in  <= l;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		shadow.predict_word(v, l);
	endtask

	// Drops the valid for a short random burst of idle cycles.
	task automatic input_gap();
		in_ch.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// Stops offering words until every expected result has come back, then lets
	// the pipeline run dry before anything else happens.
	task automatic drain_and_pause();
		in_ch.valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// Writes the mode register; only called while the block is idle.
	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.decoding = m;
	endtask

	// Every handshake on the result side is checked against the oldest expectation.
	// The values are read in the active region of the edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			shadow.compare_word(out_ch.value_out, out_ch.last_out);
	end

	// Result side: ready comes in stretches, broken by short random stalls and by
	// the one long hold-off that the stimulus asks for. Each branch lets at least
	// one edge pass, so ready is assigned at most once per edge.
	initial begin : result_side
		int n;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Input side and the overall sequence of the run.
	initial begin : stimulus
		mtfc_pkg::sym_t working_set [8];
		int             sent;
		int             phase;
		int             phase_len;
		int             buf_left;
		bit             pressing;
		mtfc_pkg::sym_t v;
		logic           l;

		in_ch.valid    <= 1'b0;
		in_ch.value_in <= '0;
		in_ch.last_in  <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= MODE_ENCODE;
		arst_n         <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encoding from the identity order: both ends of the list, a byte that
		// has just moved to the front, and the alternating bit patterns.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'h55, 1'b1);
		// The buffer has ended, so the top byte is back at the far end of the list.
		send_word(8'hFF, 1'b1);
		// A buffer is left open here so that the change of direction below works
		// on a list that has already been reordered.
		send_word(8'h10, 1'b0);
		send_word(8'h20, 1'b0);
		drain_and_pause();

		// Decoding on the same list: front, far end, and the patterned positions.
		write_mode(MODE_DECODE);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b1);
		drain_and_pause();

		// Back to encoding with the list in identity order again.
		write_mode(MODE_ENCODE);
		send_word(8'h80, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h80, 1'b1);

		// Random part. Words are grouped into buffers of random length; most close
		// with a proper last word, some are cut short. Buffers run across phase
		// boundaries, so a change of direction often falls in the middle of one.
		sent = 0;
		phase = 0;
		buf_left = 0;
		while (sent < N_RANDOM) begin
			drain_and_pause();
			if (phase < 2)
				write_mode(phase[0] ? MODE_ENCODE : MODE_DECODE);
			else
				write_mode(logic'($urandom_range(0, 1)));
			if (sent >= N_RANDOM - N_QUIET)
				quiet = 1'b1;

			// A small alphabet per phase gives the short, repetitive byte runs for
			// which move-to-front is meant, and so keeps positions near the front.
			foreach (working_set[k])
				working_set[k] = mtfc_pkg::sym_t'($urandom_range(0, 255));

			// In the third phase the result side holds off for a long while and the
			// input side keeps offering words, so the block fills and stalls its input.
			pressing = (phase == 2);
			if (pressing)
				hold_request = LONG_HOLD;

			phase_len = $urandom_range(60, 120);
			for (int i = 0; i < phase_len && sent < N_RANDOM; i++) begin
				if (buf_left == 0)
					buf_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
						: $urandom_range(1, 30);
				if (shadow.decoding == MODE_DECODE)
					v = ($urandom_range(0, 4) < 3) ? mtfc_pkg::sym_t'($urandom_range(0, 15))
						: mtfc_pkg::sym_t'($urandom_range(0, 255));
				else
					v = ($urandom_range(0, 1) == 0) ? working_set[$urandom_range(0, 7)]
						: mtfc_pkg::sym_t'($urandom_range(0, 255));
				l = (buf_left == 1);
				buf_left--;
				// Now and then a buffer is ended early.
				if ($urandom_range(0, 39) == 0) begin
					l = 1'b1;
					buf_left = 0;
				end
				send_word(v, l);
				sent++;
				if (!quiet && !pressing && $urandom_range(0, 4) == 0)
					input_gap();
			end
			phase++;
		end

		// Wait for the last results, then give the block time to show any stray word.
		in_ch.valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (3 * LAT) @(posedge clk);

		if (shadow.pending() != 0)
			$error("%0d result words never arrived", shadow.pending());
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// A correct run needs well under a quarter of this time.
	initial begin : watchdog
		#4ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mtfc_pkg.sv
rtl/mtfc_if.sv
rtl/mtfc_cell.sv
rtl/mtfc_reduce.sv
rtl/move_to_front_codec_unit.sv
bench/tb.sv
